[sv/lruk_pkg.sv]
`timescale 1ns / 1ps

package lruk_pkg;

    // Default sizes of the table.
    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    // Widths of the stream fields.
    localparam int TYPE_W   = 3;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // Request codes.
    localparam logic [TYPE_W-1:0] REQ_PUT    = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_GET    = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_REMOVE = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_PEEK   = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_MAKE   = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture a new request and clear the scan results
        logic clr_idx;  // restart the slot counter
        logic rd_en;    // read the slot at the counter and advance it
        logic scan;     // evaluate read data for match, free slot and eldest
        logic sweep;    // evaluate read data and write back the new rank
        logic commit;   // apply the request and load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_last;    // counter points at the last slot
        logic need_sweep;  // request hit and changes the ranks
        logic out_busy;    // result register still holds an untaken result
    } sts_t;

endpackage

[sv/lruk_ctrl.sv]
`timescale 1ns / 1ps

module lruk_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  lruk_pkg::sts_t sts,
    output lruk_pkg::cmd_t cmd
);
    import lruk_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        SCAN,
        SCAN_END,
        DECIDE,
        SWEEP,
        SWEEP_END,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                if (sts.idx_last)
                begin
                    state_next = SCAN_END;
                end
            end
            SCAN_END:
            begin
                state_next = DECIDE;
            end
            DECIDE:
            begin
                state_next = sts.need_sweep ? SWEEP : FINISH;
            end
            SWEEP:
            begin
                if (sts.idx_last)
                begin
                    state_next = SWEEP_END;
                end
            end
            SWEEP_END:
            begin
                state_next = FINISH;
            end
            FINISH:
            begin
                if (!sts.out_busy)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands decoded from the state.
    always_comb
    begin
        cmd         = '0;
        cmd.load    = (state_reg == IDLE) && s_tvalid;
        cmd.clr_idx = ((state_reg == IDLE) && s_tvalid) || (state_reg == DECIDE);
        cmd.rd_en   = (state_reg == SCAN) || (state_reg == SWEEP);
        cmd.scan    = (state_reg == SCAN) || (state_reg == SCAN_END);
        cmd.sweep   = (state_reg == SWEEP) || (state_reg == SWEEP_END);
        cmd.commit  = (state_reg == FINISH) && !sts.out_busy;
    end

    assign s_tready = (state_reg == IDLE);

endmodule

[sv/lruk_datapath.sv]
`timescale 1ns / 1ps

module lruk_datapath
#(
    parameter int CAPACITY    = lruk_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH   = lruk_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = lruk_pkg::DEF_VALUE_WIDTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  lruk_pkg::cmd_t                  cmd,
    output lruk_pkg::sts_t                  sts,
    input  logic [lruk_pkg::TYPE_W-1:0]     in_type,
    input  logic [lruk_pkg::FIELD_W-1:0]    in_key,
    input  logic [lruk_pkg::FIELD_W-1:0]    in_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lruk_pkg::STATUS_W-1:0]   out_status,
    output logic [lruk_pkg::FIELD_W-1:0]    out_key,
    output logic [lruk_pkg::FIELD_W-1:0]    out_value,
    output logic [lruk_pkg::COUNT_W-1:0]    out_count
);
    import lruk_pkg::*;

    localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int KW   = KEY_WIDTH;
    localparam int VW   = VALUE_WIDTH;

    // Slot storage.
    logic [KW-1:0]   key_mem  [CAPACITY];
    logic [VW-1:0]   val_mem  [CAPACITY];
    logic [IDXW-1:0] rank_mem [CAPACITY];
    logic [CAPACITY-1:0] valid_reg;
    logic [CNTW-1:0]     count_reg;

    // Captured request.
    logic [TYPE_W-1:0] type_reg;
    logic [KW-1:0]     key_reg;
    logic [VW-1:0]     val_reg;

    // Slot counter and read pipeline.
    logic [IDXW-1:0] idx_reg;
    logic [IDXW-1:0] rd_idx_reg;
    logic            rd_vld_reg;
    logic [KW-1:0]   rd_key_reg;
    logic [VW-1:0]   rd_val_reg;
    logic [IDXW-1:0] rd_rank_reg;

    // Scan results.
    logic            found_reg;
    logic [IDXW-1:0] match_idx_reg;
    logic [IDXW-1:0] match_rank_reg;
    logic [VW-1:0]   match_val_reg;
    logic            free_found_reg;
    logic [IDXW-1:0] free_idx_reg;
    logic            eld_found_reg;
    logic [KW-1:0]   eld_key_reg;
    logic [VW-1:0]   eld_val_reg;

    // Result register.
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [FIELD_W-1:0]  out_key_reg;
    logic [FIELD_W-1:0]  out_value_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    // Field width adaption: low bits of the field, zero-extended if the key is wider.
    logic [KW+FIELD_W-1:0] in_key_ext;
    logic [VW+FIELD_W-1:0] in_val_ext;
    assign in_key_ext = {{KW{1'b0}}, in_key};
    assign in_val_ext = {{VW{1'b0}}, in_value};

    // Evaluation of the slot that was read in the previous cycle.
    logic rd_slot_valid;
    logic scan_hit;
    logic sweep_act;
    assign rd_slot_valid = valid_reg[rd_idx_reg];
    assign scan_hit      = rd_vld_reg && cmd.scan;
    assign sweep_act     = rd_vld_reg && cmd.sweep && rd_slot_valid;

    // Rank rewrite during the sweep.
    logic [IDXW-1:0] newest_rank;
    logic [IDXW-1:0] sweep_rank;
    assign newest_rank = IDXW'(count_reg - CNTW'(1));

    always_comb
    begin
        sweep_rank = rd_rank_reg;
        if (rd_idx_reg == match_idx_reg)
        begin
            if (type_reg == REQ_GET)
            begin
                sweep_rank = newest_rank;
            end
            else if (type_reg == REQ_MAKE)
            begin
                sweep_rank = '0;
            end
        end
        else if (type_reg == REQ_MAKE)
        begin
            if (rd_rank_reg < match_rank_reg)
            begin
                sweep_rank = rd_rank_reg + IDXW'(1);
            end
        end
        else if (rd_rank_reg > match_rank_reg)
        begin
            sweep_rank = rd_rank_reg - IDXW'(1);
        end
    end

    // Outcome of the request at commit.
    logic [STATUS_W-1:0] res_status;
    logic [FIELD_W-1:0]  res_key;
    logic [FIELD_W-1:0]  res_value;
    logic                do_insert;
    logic                do_delete;
    logic [KW+FIELD_W-1:0] key_wide;
    logic [VW+FIELD_W-1:0] val_wide;
    logic [KW+FIELD_W-1:0] eld_key_wide;
    logic [VW+FIELD_W-1:0] eld_val_wide;
    assign key_wide     = {{FIELD_W{1'b0}}, key_reg};
    assign val_wide     = {{FIELD_W{1'b0}}, match_val_reg};
    assign eld_key_wide = {{FIELD_W{1'b0}}, eld_key_reg};
    assign eld_val_wide = {{FIELD_W{1'b0}}, eld_val_reg};

    always_comb
    begin
        res_status = ST_NOT_FOUND;
        res_key    = '0;
        res_value  = '0;
        do_insert  = 1'b0;
        do_delete  = 1'b0;
        case (type_reg)
            REQ_PUT:
            begin
                if (count_reg >= CNTW'(CAPACITY))
                begin
                    res_status = ST_FULL;
                end
                else if (found_reg)
                begin
                    res_status = ST_DUP;
                end
                else if (free_found_reg)
                begin
                    res_status = ST_OK;
                    do_insert  = 1'b1;
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            REQ_GET:
            begin
                if (found_reg)
                begin
                    res_status = ST_OK;
                    res_key    = key_wide[FIELD_W-1:0];
                    res_value  = val_wide[FIELD_W-1:0];
                end
            end
            REQ_REMOVE:
            begin
                if (found_reg)
                begin
                    res_status = ST_OK;
                    do_delete  = 1'b1;
                end
            end
            REQ_PEEK:
            begin
                res_status = ST_EMPTY;
                if ((count_reg != '0) && eld_found_reg)
                begin
                    res_status = ST_OK;
                    res_key    = eld_key_wide[FIELD_W-1:0];
                    res_value  = eld_val_wide[FIELD_W-1:0];
                end
            end
            REQ_MAKE:
            begin
                if (found_reg)
                begin
                    res_status = ST_OK;
                end
            end
            default:
            begin
                res_status = ST_NOT_FOUND;
            end
        endcase
    end

    // Count after the request.
    logic [CNTW-1:0] count_after;
    always_comb
    begin
        count_after = count_reg;
        if (do_insert)
        begin
            count_after = count_reg + CNTW'(1);
        end
        else if (do_delete)
        begin
            count_after = count_reg - CNTW'(1);
        end
    end

    logic [CNTW+COUNT_W-1:0] count_wide;
    assign count_wide = {{COUNT_W{1'b0}}, count_after};

    // Slot memories: one read port at the counter, one write port.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_key_reg  <= key_mem[idx_reg];
            rd_val_reg  <= val_mem[idx_reg];
            rd_rank_reg <= rank_mem[idx_reg];
        end
        if (cmd.commit && do_insert)
        begin
            key_mem[free_idx_reg] <= key_reg;
            val_mem[free_idx_reg] <= val_reg;
        end
        if (sweep_act)
        begin
            rank_mem[rd_idx_reg] <= sweep_rank;
        end
        else if (cmd.commit && do_insert)
        begin
            rank_mem[free_idx_reg] <= IDXW'(count_reg);
        end
    end

    // Control state of the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            if (cmd.clr_idx)
            begin
                idx_reg <= '0;
            end
            else if (cmd.rd_en && !sts.idx_last)
            begin
                idx_reg <= idx_reg + IDXW'(1);
            end
            if (cmd.commit)
            begin
                count_reg <= count_after;
                if (do_insert)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
                if (do_delete)
                begin
                    valid_reg[match_idx_reg] <= 1'b0;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture, scan results and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_idx_reg <= idx_reg;
        end
        if (cmd.load)
        begin
            type_reg       <= in_type;
            key_reg        <= in_key_ext[KW-1:0];
            val_reg        <= in_val_ext[VW-1:0];
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            eld_found_reg  <= 1'b0;
        end
        else if (scan_hit)
        begin
            if (rd_slot_valid && !found_reg && (rd_key_reg == key_reg))
            begin
                found_reg      <= 1'b1;
                match_idx_reg  <= rd_idx_reg;
                match_rank_reg <= rd_rank_reg;
                match_val_reg  <= rd_val_reg;
            end
            if (!rd_slot_valid && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= rd_idx_reg;
            end
            if (rd_slot_valid && !eld_found_reg && (rd_rank_reg == '0))
            begin
                eld_found_reg <= 1'b1;
                eld_key_reg   <= rd_key_reg;
                eld_val_reg   <= rd_val_reg;
            end
        end
        if (cmd.commit)
        begin
            out_status_reg <= res_status;
            out_key_reg    <= res_key;
            out_value_reg  <= res_value;
            out_count_reg  <= count_wide[COUNT_W-1:0];
        end
    end

    // Status to the controller.
    always_comb
    begin
        sts            = '0;
        sts.idx_last   = (idx_reg == IDXW'(CAPACITY - 1));
        sts.need_sweep = found_reg && ((type_reg == REQ_GET) || (type_reg == REQ_REMOVE)
                                       || (type_reg == REQ_MAKE));
        sts.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_key    = out_key_reg;
    assign out_value  = out_value_reg;
    assign out_count  = out_count_reg;

endmodule

[sv/lru_ordered_key_value_table_core.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// s        in         s_tvalid / s_tready  tdata: req_key, req_value; tuser: req_type
// m        out        m_tvalid / m_tready  tdata: out_key, out_value, entry_count; tuser: status
//
// One request at a time. Put, peek, misses and unused codes need one pass over the slots
// from transfer to result; a get, remove or make-eldest hit needs two, as there is
// a single slot read port: one pass to search the keys, one to rewrite ranks.
// Reset clears the valid bits and the entry count at once; the slot memories need no
// clearing. A result waits in the output register while the next request is taken;
// the request is held at its end until the previous result has been transferred.
module lru_ordered_key_value_table_core
#(
    parameter int CAPACITY    = lruk_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH   = lruk_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = lruk_pkg::DEF_VALUE_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] req_key, [63:32] req_value
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] out_key, [63:32] out_value, [68:64] entry_count
    output logic [2:0]  m_tuser    // [2:0] status
);
    import lruk_pkg::*;

    cmd_t cmd;
    sts_t sts;

    logic [FIELD_W-1:0] res_key;
    logic [FIELD_W-1:0] res_value;
    logic [COUNT_W-1:0] res_count;

    lruk_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lruk_datapath
    #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_type    (s_tuser),
        .in_key     (s_tdata[31:0]),
        .in_value   (s_tdata[63:32]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_key    (res_key),
        .out_value  (res_value),
        .out_count  (res_count)
    );

    // Pack the result fields, padded to whole bytes.
    assign m_tdata = {3'b000, res_count, res_value, res_key};

endmodule

[bench/lruk_table_checker.sv]
`timescale 1ns / 1ps

// Watches both stream channels of the table, keeps its own copy of the slots,
// and compares every result transfer with the oldest predicted result.
module lruk_table_checker
    import lruk_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] req_key, [63:32] req_value
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // [31:0] out_key, [63:32] out_value, [68:64] entry_count
    input  logic [2:0]  m_tuser,   // [2:0] status
    output int          fail_count,
    output int          results_owed
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  key;
        logic [FIELD_W-1:0]  val;
        logic [COUNT_W-1:0]  count;
    } lookup_result_t;

    // Shadow copy of the table.
    logic [FIELD_W-1:0] tbl_key [CAPACITY];
    logic [FIELD_W-1:0] tbl_val [CAPACITY];
    bit                 tbl_used [CAPACITY];
    int unsigned        tbl_rank [CAPACITY];
    int unsigned        tbl_count;

    lookup_result_t pending_results [$];

    initial
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            tbl_used[i] = 1'b0;
            tbl_rank[i] = 0;
        end
        tbl_count  = 0;
        fail_count = 0;
    end

    assign results_owed = pending_results.size();

    // Apply one request to the shadow table and return the result it must give.
    function automatic lookup_result_t apply_request(input logic [TYPE_W-1:0] op,
                                                     input logic [FIELD_W-1:0] req_key,
                                                     input logic [FIELD_W-1:0] req_val);
        lookup_result_t res;
        int             hit;
        int             free_slot;
        int unsigned    old_rank;
        res        = '0;
        res.status = ST_NOT_FOUND;
        hit        = -1;
        free_slot  = -1;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (tbl_used[i] && tbl_key[i] == req_key && hit < 0)
                hit = i;
            if (!tbl_used[i] && free_slot < 0)
                free_slot = i;
        end
        old_rank = (hit >= 0) ? tbl_rank[hit] : 0;
        case (op)
            REQ_PUT:
            begin
                // The full check wins over the duplicate check.
                if (tbl_count >= CAPACITY || free_slot < 0)
                    res.status = ST_FULL;
                else if (hit >= 0)
                    res.status = ST_DUP;
                else
                begin
                    tbl_used[free_slot] = 1'b1;
                    tbl_key[free_slot]  = req_key;
                    tbl_val[free_slot]  = req_val;
                    tbl_rank[free_slot] = tbl_count;
                    tbl_count++;
                    res.status = ST_OK;
                end
            end
            REQ_GET:
            begin
                if (hit >= 0)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (tbl_used[i] && tbl_rank[i] > old_rank)
                            tbl_rank[i]--;
                    tbl_rank[hit] = tbl_count - 1;
                    res.key    = tbl_key[hit];
                    res.val    = tbl_val[hit];
                    res.status = ST_OK;
                end
            end
            REQ_REMOVE:
            begin
                if (hit >= 0)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (tbl_used[i] && tbl_rank[i] > old_rank)
                            tbl_rank[i]--;
                    tbl_used[hit] = 1'b0;
                    tbl_rank[hit] = 0;
                    tbl_count--;
                    res.status = ST_OK;
                end
            end
            REQ_PEEK:
            begin
                res.status = ST_EMPTY;
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (tbl_used[i] && tbl_rank[i] == 0 && res.status != ST_OK)
                    begin
                        res.key    = tbl_key[i];
                        res.val    = tbl_val[i];
                        res.status = ST_OK;
                    end
                end
            end
            REQ_MAKE:
            begin
                if (hit >= 0)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (tbl_used[i] && tbl_rank[i] < old_rank)
                            tbl_rank[i]++;
                    tbl_rank[hit] = 0;
                    res.status = ST_OK;
                end
            end
            default:
                res.status = ST_NOT_FOUND;
        endcase
        res.count = tbl_count[COUNT_W-1:0];
        return res;
    endfunction

    // Results are checked before the request of the same edge is predicted, since a
    // result can never belong to a request taken at that very edge.
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no request outstanding: status %0d",
                           m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[31:0] !== want.key)
                    begin
                        $error("out_key: expected %h, actual %h", want.key, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[63:32] !== want.val)
                    begin
                        $error("out_value: expected %h, actual %h", want.val, m_tdata[63:32]);
                        fail_count++;
                    end
                    if (m_tdata[68:64] !== want.count)
                    begin
                        $error("entry_count: expected %0d, actual %0d", want.count,
                               m_tdata[68:64]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_request(s_tuser, s_tdata[31:0], s_tdata[63:32]));
        end
    end

endmodule

[bench/lru_ordered_key_value_table_core_tb.sv]
`timescale 1ns / 1ps

module lru_ordered_key_value_table_core_tb;

    import lruk_pkg::*;

    localparam int NUM_RANDOM = 550;
    localparam int POOL_SIZE  = 24;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // [31:0] req_key, [63:32] req_value
    logic [2:0]  s_tuser  = '0;   // [2:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // [31:0] out_key, [63:32] out_value, [68:64] entry_count
    logic [2:0]  m_tuser;         // [2:0] status

    int fail_count;
    int results_owed;
    int items_sent  = 0;
    bit tx_idle_en  = 1'b1;
    bit rx_idle_en  = 1'b1;

    logic [FIELD_W-1:0] key_pool [POOL_SIZE];

    always #2 clk = ~clk;

    lru_ordered_key_value_table_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lruk_table_checker i_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    // Offer one request, with an optional idle burst first, and wait for its transfer.
    task automatic send_request(input logic [TYPE_W-1:0] op,
                                input logic [FIELD_W-1:0] req_key,
                                input logic [FIELD_W-1:0] req_val);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {req_val, req_key};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // Result side: random stall bursts, and one long hold-off that backs up the block.
    initial
    begin : result_ready
        int stall_left;
        bit long_hold_done;
        stall_left     = 0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && items_sent >= 200)
            begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                m_tready   <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        int                  pick;
        bit                  filling;
        logic [TYPE_W-1:0]   op;
        logic [FIELD_W-1:0]  req_key;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: empty table, misses, unused codes, extremes and recency moves.
        send_request(REQ_PEEK,   32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_GET,    32'h0000_0000, 32'h0000_0000);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_MAKE,   32'h0000_0000, 32'h0000_0000);
        send_request(3'd5,       32'h1234_5678, 32'h9ABC_DEF0);
        send_request(3'd6,       32'h0000_0000, 32'hFFFF_FFFF);
        send_request(3'd7,       32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_PUT,    32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_PUT,    32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_PUT,    32'h0000_0000, 32'h0000_1234);
        send_request(REQ_PUT,    32'h8000_0001, 32'h7FFF_FFFE);
        send_request(REQ_PEEK,   32'h0000_0000, 32'h0000_0000);
        send_request(REQ_GET,    32'h0000_0000, 32'h0000_0000);
        send_request(REQ_PEEK,   32'h0000_0000, 32'h0000_0000);
        send_request(REQ_MAKE,   32'h0000_0000, 32'h0000_0000);
        send_request(REQ_PEEK,   32'h0000_0000, 32'h0000_0000);
        send_request(REQ_GET,    32'h8000_0001, 32'h0000_0000);
        send_request(REQ_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_PEEK,   32'h0000_0000, 32'h0000_0000);
        send_request(REQ_PUT,    32'h5555_AAAA, 32'hAAAA_5555);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_REMOVE, 32'h8000_0001, 32'h0000_0000);
        send_request(REQ_REMOVE, 32'h5555_AAAA, 32'h0000_0000);
        send_request(REQ_PEEK,   32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random part: keys come mostly from a pool larger than the table, so the table
        // fills up, hits are common, and phases alternate between filling and draining.
        filling = 1'b1;
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 40 == 0 && n > 0)
                filling = ~filling;
            if (n == NUM_RANDOM - 100)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (filling)
                op = (pick < 45) ? REQ_PUT : (pick < 65) ? REQ_GET : (pick < 73) ? REQ_REMOVE :
                     (pick < 83) ? REQ_PEEK : (pick < 95) ? REQ_MAKE :
                     3'($urandom_range(5, 7));
            else
                op = (pick < 15) ? REQ_PUT : (pick < 35) ? REQ_GET : (pick < 75) ? REQ_REMOVE :
                     (pick < 85) ? REQ_PEEK : (pick < 95) ? REQ_MAKE :
                     3'($urandom_range(5, 7));
            req_key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                    : $urandom();
            send_request(op, req_key, $urandom());
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then watch for stray transfers.
        while (results_owed != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        if (fail_count == 0 && results_owed == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
sv/lruk_pkg.sv
sv/lruk_ctrl.sv
sv/lruk_datapath.sv
sv/lru_ordered_key_value_table_core.sv
bench/lruk_table_checker.sv
bench/lru_ordered_key_value_table_core_tb.sv
